/* design/assert_macros.svh */
// assertion macros included by the controller rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every rising edge outside reset
`define ASSERT_CHECK(lbl, clk_s, rstn_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
        else $error("assertion failed");

// expression that must never be true outside reset
`define ASSERT_NEVER(lbl, clk_s, rstn_s, expr) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CHECK(lbl, clk_s, rstn_s, prop)
`define ASSERT_NEVER(lbl, clk_s, rstn_s, expr)

`endif

`endif

/* design/ggmmc_pkg.sv */
// constants and codes for the goto-goal motion mode controller
package ggmmc_pkg;

    localparam int unsigned ANGLE_FRAC_BITS = 12;
    localparam int unsigned GAIN_FRAC_BITS  = 12;

    // field widths
    localparam int unsigned DIST_W   = 24;
    localparam int unsigned ANGLE_W  = 16;
    localparam int unsigned SPEED_W  = 16;
    localparam int unsigned THR_W    = 15;
    localparam int unsigned SLOW_D_W = 23;
    localparam int unsigned GAIN_W   = 16;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned EVENT_W  = 2;
    localparam int unsigned CFG_AW   = 3;
    localparam int unsigned CFG_DW   = 23;
    localparam int unsigned IN_DW    = 40;
    localparam int unsigned OUT_DW   = 40;

    // modes
    localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ROTATE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FORWARD = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DECEL   = 2'd3;

    // latched events
    localparam logic [EVENT_W-1:0] EV_STOP     = 2'd0;
    localparam logic [EVENT_W-1:0] EV_START    = 2'd1;
    localparam logic [EVENT_W-1:0] EV_ROTATION = 2'd2;
    localparam logic [EVENT_W-1:0] EV_DECEL    = 2'd3;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_ROTATE_THRESHOLD = 3'd0;
    localparam logic [CFG_AW-1:0] REG_ANGLE_HYSTERESIS = 3'd1;
    localparam logic [CFG_AW-1:0] REG_ROTATE_SPEED     = 3'd2;
    localparam logic [CFG_AW-1:0] REG_CRUISE_SPEED     = 3'd3;
    localparam logic [CFG_AW-1:0] REG_SLOW_DISTANCE    = 3'd4;
    localparam logic [CFG_AW-1:0] REG_SLOW_SPEED       = 3'd5;
    localparam logic [CFG_AW-1:0] REG_CRUISE_GAIN      = 3'd6;
    localparam logic [CFG_AW-1:0] REG_SLOW_GAIN        = 3'd7;

    // angle resets: value in billionths scaled by 2^frac, rounded, capped to 15 bits
    localparam longint unsigned NANO_ONE  = 64'd1000000000;
    localparam longint unsigned NANO_HALF = 64'd500000000;
    localparam longint unsigned THR_MAX   = 64'd32767;
    localparam longint unsigned THR_RAW   =
        ((64'd26179939 << ANGLE_FRAC_BITS) + NANO_HALF) / NANO_ONE;
    localparam longint unsigned HYST_RAW  =
        ((64'd34906585 << ANGLE_FRAC_BITS) + NANO_HALF) / NANO_ONE;
    localparam longint unsigned RSPD_RAW  =
        ((64'd500000000 << ANGLE_FRAC_BITS) + NANO_HALF) / NANO_ONE;

    localparam logic [THR_W-1:0] ROTATE_THRESHOLD_RST =
        (THR_RAW > THR_MAX) ? THR_W'(THR_MAX) : THR_W'(THR_RAW);
    localparam logic [THR_W-1:0] ANGLE_HYSTERESIS_RST =
        (HYST_RAW > THR_MAX) ? THR_W'(THR_MAX) : THR_W'(HYST_RAW);
    localparam logic [THR_W-1:0] ROTATE_SPEED_RST =
        (RSPD_RAW > THR_MAX) ? THR_W'(THR_MAX) : THR_W'(RSPD_RAW);

    localparam logic [SPEED_W-1:0]  CRUISE_SPEED_RST  = 16'd900;
    localparam logic [SLOW_D_W-1:0] SLOW_DISTANCE_RST = 23'd1000;
    localparam logic [SPEED_W-1:0]  SLOW_SPEED_RST    = 16'd500;
    localparam logic [GAIN_W-1:0]   CRUISE_GAIN_RST   = 16'd6758;
    localparam logic [GAIN_W-1:0]   SLOW_GAIN_RST     = 16'd3379;

endpackage

/* design/goto_goal_motion_mode_controller.sv */
// goto-goal motion mode controller: mode machine, event latch and held twist
//
// Usage:
//   s_* channel carries one control tick per transfer: distance error and
//   angle error. m_* channel returns one twist command per tick: angular
//   velocity, linear velocity and the mode after that tick.
//   cfg_we/cfg_addr/cfg_wdata write the eight tuning registers; write them
//   only while no tick is in flight.
// Timing:
//   a tick is captured in an input register, then the mode, latch and twist
//   registers update from it when no result is held or the held one is being
//   taken, and the result is offered on m_*; m_tvalid comes from a register.
//   One tick per cycle is sustained while m_tready stays high; the single gain
//   multiply sits between the input register and the held twist registers.
// Reset:
//   mode idle, event latch stop, twist zero, registers at their defaults.
// Stall:
//   while m_tready is low the result holds; one more tick is taken into the
//   input register, after which s_tready drops until the result is taken.
module goto_goal_motion_mode_controller
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [23:0] goal_dist, [39:24] goal_heading
    input  logic [ggmmc_pkg::IN_DW-1:0]    s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [15:0] angular_velocity, [31:16] linear_velocity, [33:32] mode, rest zero
    output logic [ggmmc_pkg::OUT_DW-1:0]   m_tdata,
    input  logic                           cfg_we,
    input  logic [ggmmc_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [ggmmc_pkg::CFG_DW-1:0]   cfg_wdata
);

`include "assert_macros.svh"

    // configuration registers
    logic [ggmmc_pkg::THR_W-1:0]    rotate_threshold_reg;
    logic [ggmmc_pkg::THR_W-1:0]    angle_hysteresis_reg;
    logic [ggmmc_pkg::THR_W-1:0]    rotate_speed_reg;
    logic [ggmmc_pkg::SPEED_W-1:0]  cruise_speed_reg;
    logic [ggmmc_pkg::SLOW_D_W-1:0] slow_distance_reg;
    logic [ggmmc_pkg::SPEED_W-1:0]  slow_speed_reg;
    logic [ggmmc_pkg::GAIN_W-1:0]   cruise_gain_reg;
    logic [ggmmc_pkg::GAIN_W-1:0]   slow_gain_reg;

    // input stage
    logic                                 in_valid_reg;
    logic signed [ggmmc_pkg::DIST_W-1:0]  dist_reg;
    logic signed [ggmmc_pkg::ANGLE_W-1:0] angle_reg;

    // controller state, also the result payload
    logic                                 out_valid_reg;
    logic [ggmmc_pkg::MODE_W-1:0]         mode_reg;
    logic [ggmmc_pkg::MODE_W-1:0]         mode_next;
    logic [ggmmc_pkg::EVENT_W-1:0]        event_reg;
    logic [ggmmc_pkg::EVENT_W-1:0]        event_next;
    logic [ggmmc_pkg::ANGLE_W-1:0]        held_angular_reg;
    logic [ggmmc_pkg::ANGLE_W-1:0]        held_angular_next;
    logic [ggmmc_pkg::SPEED_W-1:0]        held_linear_reg;
    logic [ggmmc_pkg::SPEED_W-1:0]        held_linear_next;

    logic advance;
    logic step;

    // datapath
    logic [ggmmc_pkg::ANGLE_W-1:0]   angle_mag;
    logic                            angle_neg;
    logic                            dist_zero;
    logic                            angle_zero;
    logic                            below_thr;
    logic                            above_hyst;
    logic                            below_slow;
    logic [ggmmc_pkg::ANGLE_W-1:0]   thr_plus_hyst;
    logic [ggmmc_pkg::GAIN_W-1:0]    gain_sel;
    logic [31:0]                     prod;
    logic [32:0]                     prod_rnd;
    logic [20:0]                     prod_scaled;
    logic [ggmmc_pkg::ANGLE_W-1:0]   gain_turn;
    logic [ggmmc_pkg::ANGLE_W-1:0]   rotate_turn;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, mode_reg, held_linear_reg, held_angular_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotate_threshold_reg <= ggmmc_pkg::ROTATE_THRESHOLD_RST;
            angle_hysteresis_reg <= ggmmc_pkg::ANGLE_HYSTERESIS_RST;
            rotate_speed_reg     <= ggmmc_pkg::ROTATE_SPEED_RST;
            cruise_speed_reg     <= ggmmc_pkg::CRUISE_SPEED_RST;
            slow_distance_reg    <= ggmmc_pkg::SLOW_DISTANCE_RST;
            slow_speed_reg       <= ggmmc_pkg::SLOW_SPEED_RST;
            cruise_gain_reg      <= ggmmc_pkg::CRUISE_GAIN_RST;
            slow_gain_reg        <= ggmmc_pkg::SLOW_GAIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                ggmmc_pkg::REG_ROTATE_THRESHOLD: rotate_threshold_reg <= cfg_wdata[14:0];
                ggmmc_pkg::REG_ANGLE_HYSTERESIS: angle_hysteresis_reg <= cfg_wdata[14:0];
                ggmmc_pkg::REG_ROTATE_SPEED:     rotate_speed_reg     <= cfg_wdata[14:0];
                ggmmc_pkg::REG_CRUISE_SPEED:     cruise_speed_reg     <= cfg_wdata[15:0];
                ggmmc_pkg::REG_SLOW_DISTANCE:    slow_distance_reg    <= cfg_wdata[22:0];
                ggmmc_pkg::REG_SLOW_SPEED:       slow_speed_reg       <= cfg_wdata[15:0];
                ggmmc_pkg::REG_CRUISE_GAIN:      cruise_gain_reg      <= cfg_wdata[15:0];
                ggmmc_pkg::REG_SLOW_GAIN:        slow_gain_reg        <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            dist_reg  <= s_tdata[23:0];
            angle_reg <= s_tdata[39:24];
        end
    end

    // tick evaluation
    always_comb
    begin
        angle_neg     = angle_reg[ggmmc_pkg::ANGLE_W-1];
        angle_mag     = angle_neg ? 16'(-angle_reg) : 16'(angle_reg);
        dist_zero     = (dist_reg == '0);
        angle_zero    = (angle_reg == '0);
        below_thr     = (angle_mag < {1'b0, rotate_threshold_reg});
        thr_plus_hyst = {1'b0, rotate_threshold_reg} + {1'b0, angle_hysteresis_reg};
        above_hyst    = (angle_mag > thr_plus_hyst);
        below_slow    = (dist_reg < $signed({1'b0, slow_distance_reg}));

        gain_sel    = (mode_reg == ggmmc_pkg::MODE_FORWARD) ? cruise_gain_reg : slow_gain_reg;
        prod        = 32'(angle_mag) * 32'(gain_sel);
        // round half away from zero on the magnitude
        prod_rnd    = {1'b0, prod} + 33'(1 << (ggmmc_pkg::GAIN_FRAC_BITS - 1));
        prod_scaled = 21'(prod_rnd >> ggmmc_pkg::GAIN_FRAC_BITS);
        if (angle_neg)
        begin
            gain_turn = (prod_scaled > 21'd32768) ? 16'h8000 : 16'(21'd0 - prod_scaled);
        end
        else
        begin
            gain_turn = (prod_scaled > 21'd32767) ? 16'h7fff : prod_scaled[15:0];
        end
        rotate_turn = angle_neg ? 16'(-$signed({1'b0, rotate_speed_reg}))
                                : {1'b0, rotate_speed_reg};

        mode_next         = mode_reg;
        event_next        = event_reg;
        held_angular_next = held_angular_reg;
        held_linear_next  = held_linear_reg;

        unique case (mode_reg)
            ggmmc_pkg::MODE_IDLE:
            begin
                if (!dist_zero)
                begin
                    event_next = below_thr ? ggmmc_pkg::EV_START : ggmmc_pkg::EV_ROTATION;
                end
                if (event_next == ggmmc_pkg::EV_START)
                begin
                    mode_next = ggmmc_pkg::MODE_FORWARD;
                end
                else if (event_next == ggmmc_pkg::EV_ROTATION)
                begin
                    mode_next = ggmmc_pkg::MODE_ROTATE;
                end
                else
                begin
                    held_angular_next = '0;
                    held_linear_next  = '0;
                end
            end
            ggmmc_pkg::MODE_ROTATE:
            begin
                if (below_thr)
                begin
                    event_next = ggmmc_pkg::EV_START;
                end
                if (angle_zero && dist_zero)
                begin
                    event_next = ggmmc_pkg::EV_STOP;
                end
                if (event_next == ggmmc_pkg::EV_START || event_next == ggmmc_pkg::EV_STOP)
                begin
                    mode_next = (event_next == ggmmc_pkg::EV_START) ?
                                ggmmc_pkg::MODE_FORWARD : ggmmc_pkg::MODE_IDLE;
                    held_angular_next = '0;
                    held_linear_next  = '0;
                end
                else
                begin
                    held_angular_next = rotate_turn;
                    held_linear_next  = '0;
                end
            end
            ggmmc_pkg::MODE_FORWARD:
            begin
                // signed compare: a negative distance also slows down
                if (below_slow)
                begin
                    event_next = ggmmc_pkg::EV_DECEL;
                end
                if (above_hyst)
                begin
                    event_next = ggmmc_pkg::EV_ROTATION;
                end
                if (dist_zero && angle_zero)
                begin
                    event_next = ggmmc_pkg::EV_STOP;
                end
                if (event_next == ggmmc_pkg::EV_DECEL)
                begin
                    mode_next = ggmmc_pkg::MODE_DECEL;
                end
                else if (event_next == ggmmc_pkg::EV_ROTATION ||
                         event_next == ggmmc_pkg::EV_STOP)
                begin
                    mode_next = (event_next == ggmmc_pkg::EV_ROTATION) ?
                                ggmmc_pkg::MODE_ROTATE : ggmmc_pkg::MODE_IDLE;
                    held_angular_next = '0;
                    held_linear_next  = '0;
                end
                else
                begin
                    held_angular_next = gain_turn;
                    held_linear_next  = cruise_speed_reg;
                end
            end
            default:
            begin
                if (dist_zero)
                begin
                    event_next = ggmmc_pkg::EV_STOP;
                end
                if (event_next == ggmmc_pkg::EV_STOP)
                begin
                    mode_next         = ggmmc_pkg::MODE_IDLE;
                    held_angular_next = '0;
                    held_linear_next  = '0;
                end
                else
                begin
                    held_angular_next = gain_turn;
                    held_linear_next  = slow_speed_reg;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            mode_reg         <= ggmmc_pkg::MODE_IDLE;
            event_reg        <= ggmmc_pkg::EV_STOP;
            held_angular_reg <= '0;
            held_linear_reg  <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (step)
            begin
                mode_reg         <= mode_next;
                event_reg        <= event_next;
                held_angular_reg <= held_angular_next;
                held_linear_reg  <= held_linear_next;
            end
        end
    end

    `ASSERT_CHECK(a_idle_no_twist, clk, rst_n,
        (mode_reg == ggmmc_pkg::MODE_IDLE) |-> (held_angular_reg == '0 && held_linear_reg == '0))
    `ASSERT_NEVER(a_rotate_no_linear, clk, rst_n,
        mode_reg == ggmmc_pkg::MODE_ROTATE && held_linear_reg != '0)
    `ASSERT_CHECK(a_idle_not_to_decel, clk, rst_n,
        (mode_reg == ggmmc_pkg::MODE_IDLE) |=> (mode_reg != ggmmc_pkg::MODE_DECEL))
    `ASSERT_CHECK(a_state_holds_without_step, clk, rst_n,
        !step |=> ($stable(mode_reg) && $stable(event_reg) && $stable(held_angular_reg)))
    `ASSERT_CHECK(a_result_leaves_on_transfer, clk, rst_n,
        $fell(out_valid_reg) |-> $past(m_tready))

endmodule
